// File: rtl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared widths, fixed-point format and register indexes for the escape-time
// fractal iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

    // signed coordinate format: 32 bits with COORD_FRAC_BITS fraction bits
    localparam int COORD_FRAC_BITS = 26;
    localparam int COORD_W         = 32;
    localparam int PROD_W          = 2 * COORD_W;
    localparam int COUNT_W         = 16;

    // |z|^2 compare width: holds both the 2F-fraction magnitude and limit << F
    localparam int CMP_W           = PROD_W + COORD_FRAC_BITS;

    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRACTAL_MODE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ITERATIONS = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ESCAPE_LIMIT   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_JULIA_RE       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_JULIA_IM       = 3'd4;

    localparam logic               MODE_MANDELBROT      = 1'b0;
    localparam logic [COUNT_W-1:0] MAX_ITERATIONS_RESET = 16'd64;
    localparam logic [COORD_W-1:0] ESCAPE_LIMIT_RESET   = 32'd268435456;

endpackage

// File: rtl/etf_mul.sv
// ----------------------------------------------------------------------------
// etf_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module etf_mul (
    input  logic                               aclk,
    input  logic signed [etf_pkg::COORD_W-1:0] op_a,
    input  logic signed [etf_pkg::COORD_W-1:0] op_b,
    output logic signed [etf_pkg::PROD_W-1:0]  prod
);

    logic signed [etf_pkg::PROD_W-1:0] prod_reg;
    logic signed [etf_pkg::PROD_W-1:0] prod_next;

    // both operands signed: sign-extended to the product width
    assign prod_next = op_a * op_b;
    assign prod      = prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

// File: rtl/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Mandelbrot / Julia escape-time iteration in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one plane point (s_point_re, s_point_im) per item.
//   m_valid/m_ready return one result per item: m_iteration_count and
//   m_escaped. The cfg_* port writes the mode, limit, escape threshold and
//   Julia constant, one register per cycle at cfg_wr_en; the user must
//   write only while idle, which the block itself does not enforce.
//   One item is worked at a time. Each iteration z <- z*z + c runs on
//   the single shared 32x32 multiplier in the steps x*x, y*y and x*y,
//   with the escape test of z folded into the x*y step. The default
//   iteration limit is 64. The result sits in an output register, so
//   the next point is accepted as soon as the result is registered, even
//   if the receiver stalls. A second result waits in the sequencer until
//   the output register frees up. Reset (aresetn low, synchronous) drops
//   any item in flight, clears the output valid and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator (
    input  logic                                     aclk,
    input  logic                                     aresetn,

    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [etf_pkg::COORD_W-1:0]       s_point_re,
    input  logic signed [etf_pkg::COORD_W-1:0]       s_point_im,

    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic        [etf_pkg::COUNT_W-1:0]       m_iteration_count,
    output logic                                     m_escaped,

    input  logic                                     cfg_wr_en,
    input  logic        [etf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic        [etf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int F = etf_pkg::COORD_FRAC_BITS;
    localparam int W = etf_pkg::COORD_W;
    localparam int P = etf_pkg::PROD_W;
    localparam int N = etf_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_XY,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;

    logic                 mode_reg, mode_next;
    logic [N-1:0]         max_iter_reg, max_iter_next;
    logic [W-1:0]         esc_limit_reg, esc_limit_next;
    logic signed [W-1:0]  julia_re_reg, julia_re_next;
    logic signed [W-1:0]  julia_im_reg, julia_im_next;

    logic signed [W-1:0]  x_reg, x_next;
    logic signed [W-1:0]  y_reg, y_next;
    logic signed [W-1:0]  cre_reg, cre_next;
    logic signed [W-1:0]  cim_reg, cim_next;
    logic signed [P-1:0]  aa_reg, aa_next;
    logic [N-1:0]         count_reg, count_next;
    logic                 first_reg, first_next;
    logic                 ovf_reg, ovf_next;

    logic                 m_valid_reg, m_valid_next;
    logic [N-1:0]         m_count_reg, m_count_next;
    logic                 m_escaped_reg, m_escaped_next;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [P-1:0]  prod;

    logic signed [P-1:0]  re_diff, re_sum, im_sum;
    logic                 ovf_x, ovf_y;
    logic [P-1:0]         mag;
    logic [etf_pkg::CMP_W-1:0] mag_ext, lim_ext;
    logic                 beyond, esc;
    logic [N-1:0]         count_inc;

    etf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // multiplier operand select
    always_comb begin
        case (state_reg)
            ST_SQX: begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ST_SQY: begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default: begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    // new real part, valid in ST_XY: prod holds y*y, aa_reg holds x*x
    assign re_diff = aa_reg - prod;
    assign re_sum  = (re_diff >>> F) + $signed({{(P-W){cre_reg[W-1]}}, cre_reg});
    assign ovf_x   = (re_sum[P-1:W-1] != '0) && (re_sum[P-1:W-1] != '1);

    // new imaginary part, valid in ST_SQX after a step: prod holds x*y
    assign im_sum  = (prod >>> (F - 1)) + $signed({{(P-W){cim_reg[W-1]}}, cim_reg});
    assign ovf_y   = (im_sum[P-1:W-1] != '0) && (im_sum[P-1:W-1] != '1);

    // exact |z|^2 > limit, squares are non-negative
    assign mag     = $unsigned(aa_reg) + $unsigned(prod);
    assign mag_ext = etf_pkg::CMP_W'(mag);
    assign lim_ext = etf_pkg::CMP_W'(esc_limit_reg) << F;
    assign beyond  = mag_ext > lim_ext;

    // the start point is never tested
    assign esc       = !first_reg && (ovf_reg || beyond);
    assign count_inc = count_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        max_iter_next  = max_iter_reg;
        esc_limit_next = esc_limit_reg;
        julia_re_next  = julia_re_reg;
        julia_im_next  = julia_im_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        aa_next        = aa_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        ovf_next       = ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_count_next   = m_count_reg;
        m_escaped_next = m_escaped_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                etf_pkg::CFG_FRACTAL_MODE:   mode_next      = cfg_wdata[0];
                etf_pkg::CFG_MAX_ITERATIONS: max_iter_next  = cfg_wdata[N-1:0];
                etf_pkg::CFG_ESCAPE_LIMIT:   esc_limit_next = cfg_wdata[W-1:0];
                etf_pkg::CFG_JULIA_RE:       julia_re_next  = $signed(cfg_wdata[W-1:0]);
                etf_pkg::CFG_JULIA_IM:       julia_im_next  = $signed(cfg_wdata[W-1:0]);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (mode_reg == etf_pkg::MODE_MANDELBROT) begin
                        x_next   = '0;
                        y_next   = '0;
                        cre_next = s_point_re;
                        cim_next = s_point_im;
                    end else begin
                        x_next   = s_point_re;
                        y_next   = s_point_im;
                        cre_next = julia_re_reg;
                        cim_next = julia_im_reg;
                    end
                    count_next = '0;
                    first_next = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                // finish the previous step's imaginary part
                if (!first_reg) begin
                    y_next   = im_sum[W-1:0];
                    ovf_next = ovf_reg || ovf_y;
                end
                state_next = ST_SQY;
            end
            ST_SQY: begin
                aa_next    = prod;
                state_next = ST_XY;
            end
            ST_XY: begin
                if (esc) begin
                    state_next = ST_DONE;
                end else if (mode_reg == etf_pkg::MODE_MANDELBROT) begin
                    if (count_reg >= max_iter_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        count_next = count_inc;
                        x_next     = re_sum[W-1:0];
                        ovf_next   = ovf_x;
                        first_next = 1'b0;
                        state_next = ST_SQX;
                    end
                end else begin
                    // Julia counts a step only once it has passed the test
                    if (!first_reg) begin
                        count_next = count_inc;
                    end
                    if ((first_reg ? count_reg : count_inc) >= max_iter_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        x_next     = re_sum[W-1:0];
                        ovf_next   = ovf_x;
                        first_next = 1'b0;
                        state_next = ST_SQX;
                    end
                end
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_count_next   = count_reg;
                    m_escaped_next = count_reg < max_iter_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= etf_pkg::MODE_MANDELBROT;
            max_iter_reg  <= etf_pkg::MAX_ITERATIONS_RESET;
            esc_limit_reg <= etf_pkg::ESCAPE_LIMIT_RESET;
            julia_re_reg  <= '0;
            julia_im_reg  <= '0;
            m_valid_reg   <= 1'b0;
            first_reg     <= 1'b0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            max_iter_reg  <= max_iter_next;
            esc_limit_reg <= esc_limit_next;
            julia_re_reg  <= julia_re_next;
            julia_im_reg  <= julia_im_next;
            m_valid_reg   <= m_valid_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
        end
        x_reg         <= x_next;
        y_reg         <= y_next;
        cre_reg       <= cre_next;
        cim_reg       <= cim_next;
        aa_reg        <= aa_next;
        ovf_reg       <= ovf_next;
        m_count_reg   <= m_count_next;
        m_escaped_reg <= m_escaped_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_escaped         = m_escaped_reg;

    // an accepted item starts a fresh, untested run
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SQX && first_reg && count_reg == '0))
        else $error("item start did not initialize the iteration");

    // the square of y always follows the square of x
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQY) |-> ($past(state_reg) == ST_SQX))
        else $error("y*y issued out of sequence");

    // nothing is counted before the first step has been tested
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && first_reg) |-> (count_reg == '0))
        else $error("count advanced before the first step");

    // a finished item reaches the output register once it is free
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_ready))
        |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished item not delivered to the output register");

endmodule
